@@ sv/markup_tag_strip_entity_decode_unit_macros.svh @@
// Assertion macros shared by the markup tag strip and entity decode RTL.
`ifndef MARKUP_TAG_STRIP_ENTITY_DECODE_UNIT_MACROS_SVH
`define MARKUP_TAG_STRIP_ENTITY_DECODE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define MTSED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Antecedent implies consequent in the next cycle.
`define MTSED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MTSED_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define MTSED_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ sv/mtsed_pkg.sv @@
// Types, character constants and entity decode functions for the markup filter.
package mtsed_pkg;

   typedef enum logic [3:0] {
      MODE_NORMAL  = 4'b0001,
      MODE_WINDOW  = 4'b0010,
      MODE_SWALLOW = 4'b0100,
      MODE_DONE    = 4'b1000
   } mode_type;

   // Progress of the numeric entity parser over the bytes after '#'.
   typedef enum logic [6:0] {
      PH_WS    = 7'b0000001,
      PH_SIGN  = 7'b0000010,
      PH_ZERO  = 7'b0000100,
      PH_DIG8  = 7'b0001000,
      PH_DIG10 = 7'b0010000,
      PH_DIG16 = 7'b0100000,
      PH_STOP  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic      amp;
      logic      lt;
      logic      gt;
      logic      nbsp;
      logic      apos;
      logic      hash;
      logic      neg;
      phase_type phase;
      logic [7:0] acc;
   } ent_type;

   localparam ent_type ENT_INIT = '{amp: 1'b1, lt: 1'b1, gt: 1'b1, nbsp: 1'b1,
                                    apos: 1'b1, hash: 1'b1, neg: 1'b0,
                                    phase: PH_WS, acc: 8'h00};

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_APOS  = 8'h27;
   localparam logic [7:0] CHAR_QUERY = 8'h3F;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   // Entity names, left aligned, without the leading '&'.
   localparam logic [31:0] PAT_AMP  = {"amp", 8'h00};
   localparam logic [31:0] PAT_LT   = {"lt", 16'h0000};
   localparam logic [31:0] PAT_GT   = {"gt", 16'h0000};
   localparam logic [31:0] PAT_NBSP = "nbsp";
   localparam logic [31:0] PAT_APOS = "apos";
   localparam logic [31:0] PAT_HASH = {"#", 24'h000000};

   localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
   localparam logic signed [15:0] DEPTH_MIN = -16'sh8000;

   // A candidate name stays matched when the byte lies past its end or agrees.
   function automatic logic prefix_keep(input logic [31:0] pat, input logic [3:0] len,
                                        input logic [3:0] pos, input logic [7:0] b);
      logic [7:0] c;
      c = 8'h00;
      case (pos)
         4'd0:    c = pat[31:24];
         4'd1:    c = pat[23:16];
         4'd2:    c = pat[15:8];
         4'd3:    c = pat[7:0];
         default: c = 8'h00;
      endcase
      return (pos >= len) || (b == c);
   endfunction

   // Hex digit value, or 16 for anything that is no digit.
   function automatic logic [4:0] digit_value(input logic [7:0] b);
      logic [4:0] d;
      d = 5'd16;
      if (b >= "0" && b <= "9") d = 5'(b - "0");
      else if (b >= "a" && b <= "f") d = 5'(b - "a" + 8'd10);
      else if (b >= "A" && b <= "F") d = 5'(b - "A" + 8'd10);
      return d;
   endfunction

   // Advances the number parser by one byte. Only the low 8 bits of the
   // value are kept, which is all the result needs.
   function automatic ent_type num_step(input ent_type e, input logic [7:0] b);
      ent_type    r;
      logic [4:0] d;
      logic [7:0] d8;
      logic       ws;
      r  = e;
      d  = digit_value(b);
      d8 = {3'b000, d};
      ws = (b == CHAR_SPACE) || (b >= 8'd9 && b <= 8'd13);
      unique case (e.phase)
         PH_WS: begin
            if (ws) begin
               r.phase = PH_WS;
            end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
               r.neg   = (b == CHAR_MINUS);
               r.phase = PH_SIGN;
            end else if (b == CHAR_ZERO) begin
               r.phase = PH_ZERO;
            end else if (d < 5'd10) begin
               r.acc   = d8;
               r.phase = PH_DIG10;
            end else begin
               r.phase = PH_STOP;
            end
         end
         PH_SIGN: begin
            if (b == CHAR_ZERO) begin
               r.phase = PH_ZERO;
            end else if (d < 5'd10) begin
               r.acc   = d8;
               r.phase = PH_DIG10;
            end else begin
               r.phase = PH_STOP;
            end
         end
         PH_ZERO: begin
            if (b == "x" || b == "X") begin
               r.phase = PH_DIG16;
            end else if (d < 5'd8) begin
               r.acc   = d8;
               r.phase = PH_DIG8;
            end else begin
               r.phase = PH_STOP;
            end
         end
         PH_DIG8: begin
            if (d < 5'd8) r.acc = {e.acc[4:0], 3'b000} + d8;
            else r.phase = PH_STOP;
         end
         PH_DIG10: begin
            if (d < 5'd10) r.acc = {e.acc[4:0], 3'b000} + {e.acc[6:0], 1'b0} + d8;
            else r.phase = PH_STOP;
         end
         PH_DIG16: begin
            if (d < 5'd16) r.acc = {e.acc[3:0], 4'b0000} + d8;
            else r.phase = PH_STOP;
         end
         PH_STOP: r.phase = PH_STOP;
         default: r.phase = PH_STOP;
      endcase
      return r;
   endfunction

   // Takes one more window byte at position pos (position 0 follows the '&').
   function automatic ent_type ent_append(input ent_type e, input logic [3:0] pos,
                                          input logic [7:0] b);
      ent_type r;
      r = (pos != 4'd0) ? num_step(e, b) : e;
      r.amp  = e.amp  && prefix_keep(PAT_AMP,  4'd3, pos, b);
      r.lt   = e.lt   && prefix_keep(PAT_LT,   4'd2, pos, b);
      r.gt   = e.gt   && prefix_keep(PAT_GT,   4'd2, pos, b);
      r.nbsp = e.nbsp && prefix_keep(PAT_NBSP, 4'd4, pos, b);
      r.apos = e.apos && prefix_keep(PAT_APOS, 4'd4, pos, b);
      r.hash = e.hash && prefix_keep(PAT_HASH, 4'd1, pos, b);
      return r;
   endfunction

   // Character for a window holding cnt bytes after the '&'.
   function automatic logic [7:0] ent_decode(input ent_type e, input logic [3:0] cnt);
      logic [7:0] c;
      if (e.amp && cnt >= 4'd3) c = CHAR_AMP;
      else if (e.lt && cnt >= 4'd2) c = CHAR_LT;
      else if (e.gt && cnt >= 4'd2) c = CHAR_GT;
      else if (e.nbsp && cnt >= 4'd4) c = CHAR_SPACE;
      else if (e.apos && cnt >= 4'd4) c = CHAR_APOS;
      else if (e.hash && cnt >= 4'd1) c = e.neg ? (8'h00 - e.acc) : e.acc;
      else c = CHAR_QUERY;
      return c;
   endfunction

endpackage

@@ sv/markup_tag_strip_entity_decode_unit.sv @@
// Markup filter: strips tags, skips CR, decodes entities and caps the text length.
//
//  Channel  Direction  Signals                              Carries
//  req_     in         tvalid tready tdata[7:0] tlast       source byte, last byte of text
//  rsp_     out        tvalid tready tdata[7:0] tuser tlast character, char flag, end of text
//  csr_     in         wr_en wr_data[15:0]                  max_chars
//
// One byte per cycle sustained while rsp_tready is high. A byte is registered in the input
// register and filtered into the result register on its way out.
// Stalls on rsp_tready hold both registers; req_tready then drops in the same cycle if a byte waits.
// Reset clears the text state and sets max_chars to 512.
`include "markup_tag_strip_entity_decode_unit_macros.svh"

module markup_tag_strip_entity_decode_unit #(
   parameter int ENTITY_SPAN = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_char
   output logic        rsp_tuser,    // [0] char_valid
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int CW = $clog2(ENTITY_SPAN);
   localparam logic [CW-1:0] WIN_FULL = CW'(ENTITY_SPAN - 1);

   logic [15:0] max_chars_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic              out_valid_ff;
   logic [7:0]        out_char_ff;
   logic              out_cv_ff;
   logic              out_last_ff;

   mtsed_pkg::mode_type mode_ff, mode_in;
   logic signed [15:0]  depth_ff, depth_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   mtsed_pkg::ent_type  ent_ff, ent_in;
   logic [15:0]         emitted_ff, emitted_in;

   logic       advance;
   logic       have_res;
   logic [7:0] res_char;
   logic       res_cv;
   logic       res_last;

   logic               emit;
   logic [7:0]         emit_char;
   logic               end_now;
   logic               restart;
   logic               dropped;
   logic [CW-1:0]      cnt_inc;
   mtsed_pkg::ent_type ent_app;
   logic signed [15:0] depth_step;
   logic [15:0]        emitted_inc;
   logic               cut;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tuser  = out_cv_ff;
   assign rsp_tlast  = out_last_ff;

   assign cnt_inc     = cnt_ff + 1'b1;
   assign ent_app     = mtsed_pkg::ent_append(ent_ff, 4'(cnt_ff), in_byte_ff);
   assign emitted_inc = (emitted_ff == 16'hFFFF) ? emitted_ff : emitted_ff + 16'd1;
   assign cut         = (max_chars_ff != 16'd0) && (emitted_inc >= max_chars_ff);

   always_comb begin
      mode_in    = mode_ff;
      depth_in   = depth_ff;
      cnt_in     = cnt_ff;
      ent_in     = ent_ff;
      emitted_in = emitted_ff;
      have_res   = 1'b0;
      res_char   = 8'h00;
      res_cv     = 1'b0;
      res_last   = 1'b0;
      emit       = 1'b0;
      emit_char  = 8'h00;
      end_now    = 1'b0;
      restart    = 1'b0;
      dropped    = 1'b0;
      depth_step = depth_ff;

      unique case (mode_ff)
         mtsed_pkg::MODE_DONE: begin
            restart = in_last_ff;
         end
         mtsed_pkg::MODE_SWALLOW: begin
            if (in_byte_ff == mtsed_pkg::CHAR_NUL) begin
               have_res = 1'b1;
               res_last = 1'b1;
               if (in_last_ff) restart = 1'b1;
               else mode_in = mtsed_pkg::MODE_DONE;
            end else if (in_last_ff) begin
               have_res = 1'b1;
               res_last = 1'b1;
               restart  = 1'b1;
            end else begin
               mode_in = mtsed_pkg::MODE_NORMAL;
            end
         end
         mtsed_pkg::MODE_WINDOW: begin
            end_now = in_last_ff || (in_byte_ff == mtsed_pkg::CHAR_NUL);
            restart = in_last_ff;
            if (in_byte_ff == mtsed_pkg::CHAR_NUL || in_byte_ff == mtsed_pkg::CHAR_SEMI) begin
               emit      = 1'b1;
               emit_char = mtsed_pkg::ent_decode(ent_ff, 4'(cnt_ff));
               mode_in   = mtsed_pkg::MODE_NORMAL;
            end else begin
               ent_in = ent_app;
               cnt_in = cnt_inc;
               if (cnt_inc >= WIN_FULL) begin
                  // Full window: decode now and drop the byte that follows.
                  emit      = 1'b1;
                  emit_char = mtsed_pkg::ent_decode(ent_app, 4'(cnt_inc));
                  mode_in   = mtsed_pkg::MODE_SWALLOW;
               end else if (in_last_ff) begin
                  emit      = 1'b1;
                  emit_char = mtsed_pkg::ent_decode(ent_app, 4'(cnt_inc));
               end
            end
         end
         mtsed_pkg::MODE_NORMAL: begin
            if (in_byte_ff == mtsed_pkg::CHAR_NUL || in_byte_ff == mtsed_pkg::CHAR_LF) begin
               have_res = 1'b1;
               res_last = 1'b1;
               if (in_last_ff) restart = 1'b1;
               else mode_in = mtsed_pkg::MODE_DONE;
            end else if (in_byte_ff == mtsed_pkg::CHAR_CR) begin
               dropped = 1'b1;
            end else if (in_byte_ff == mtsed_pkg::CHAR_GT) begin
               if (depth_ff != mtsed_pkg::DEPTH_MIN) depth_in = depth_ff - 16'sd1;
               dropped = 1'b1;
            end else begin
               if (in_byte_ff == mtsed_pkg::CHAR_LT && depth_ff != mtsed_pkg::DEPTH_MAX) begin
                  depth_step = depth_ff + 16'sd1;
               end
               depth_in = depth_step;
               if (depth_step > 16'sd0) begin
                  dropped = 1'b1;
               end else if (in_byte_ff == mtsed_pkg::CHAR_AMP) begin
                  cnt_in = '0;
                  ent_in = mtsed_pkg::ENT_INIT;
                  if (in_last_ff) begin
                     emit      = 1'b1;
                     emit_char = mtsed_pkg::ent_decode(mtsed_pkg::ENT_INIT, 4'd0);
                     end_now   = 1'b1;
                     restart   = 1'b1;
                  end else begin
                     mode_in = mtsed_pkg::MODE_WINDOW;
                  end
               end else begin
                  emit      = 1'b1;
                  emit_char = in_byte_ff;
                  end_now   = in_last_ff;
                  restart   = in_last_ff;
               end
            end
            if (dropped && in_last_ff) begin
               have_res = 1'b1;
               res_last = 1'b1;
               restart  = 1'b1;
            end
         end
         default: mode_in = mtsed_pkg::MODE_DONE;
      endcase

      if (emit) begin
         have_res   = 1'b1;
         res_cv     = 1'b1;
         res_char   = emit_char;
         emitted_in = emitted_inc;
         if (end_now || cut) begin
            res_last = 1'b1;
            mode_in  = mtsed_pkg::MODE_DONE;
         end
      end

      // A final byte always leaves the next byte at the start of a new text.
      if (restart) begin
         mode_in    = mtsed_pkg::MODE_NORMAL;
         depth_in   = 16'sd0;
         cnt_in     = '0;
         emitted_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= 16'd512;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= mtsed_pkg::MODE_NORMAL;
         depth_ff     <= 16'sd0;
         cnt_ff       <= '0;
         emitted_ff   <= 16'd0;
      end else begin
         if (csr_wr_en) max_chars_ff <= csr_wr_data;
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) begin
            out_valid_ff <= have_res;
            mode_ff      <= mode_in;
            depth_ff     <= depth_in;
            cnt_ff       <= cnt_in;
            emitted_ff   <= emitted_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         ent_ff      <= ent_in;
         out_char_ff <= res_char;
         out_cv_ff   <= res_cv;
         out_last_ff <= res_last;
      end
   end

   `MTSED_ASSERT_NOW(a_endonly_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 8'h00, "end-only transaction carries a nonzero character")
   `MTSED_ASSERT_NOW(a_endonly_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast, "transaction without a character does not close the text")
   `MTSED_ASSERT_NOW(a_window_bound, clock, reset, mode_ff == mtsed_pkg::MODE_WINDOW, cnt_ff < WIN_FULL, "entity window count reached its limit while still open")
   `MTSED_ASSERT_NEXT(a_last_restart, clock, reset, advance && in_last_ff, mode_ff == mtsed_pkg::MODE_NORMAL && depth_ff == 16'sd0 && emitted_ff == 16'd0, "final byte did not restart the text state")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the markup tag strip and entity decode unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENT_SPAN = 7;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int STALL_CYCLES = 150;
   localparam int PHASE_ITEMS = 370;
   localparam int ITEMS_PER_CAP = 96;

   typedef struct packed {
      logic [7:0] ch;
      logic       valid;
      logic       last;
   } text_char_type;

   typedef struct packed {
      logic [7:0]    b;
      logic          l;
      logic          typed;
      text_char_type want;
   } dir_row_type;

   localparam text_char_type NO_CHAR  = '0;
   localparam text_char_type END_ONLY = '{ch: 8'h00, valid: 1'b0, last: 1'b1};

   // Rows with typed set carry an expectation that is obvious from the rules.
   localparam dir_row_type DIR_ROWS [27] = '{
      '{8'hFF,                 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
      '{mtsed_pkg::CHAR_LT,    1'b0, 1'b0, NO_CHAR},
      '{mtsed_pkg::CHAR_GT,    1'b0, 1'b0, NO_CHAR},
      '{mtsed_pkg::CHAR_GT,    1'b0, 1'b0, NO_CHAR},
      '{mtsed_pkg::CHAR_LT,    1'b0, 1'b1, '{mtsed_pkg::CHAR_LT, 1'b1, 1'b0}},
      '{mtsed_pkg::CHAR_CR,    1'b0, 1'b0, NO_CHAR},
      '{mtsed_pkg::CHAR_AMP,   1'b0, 1'b0, NO_CHAR},
      '{"g",                   1'b0, 1'b0, NO_CHAR},
      '{"t",                   1'b0, 1'b0, NO_CHAR},
      '{mtsed_pkg::CHAR_SEMI,  1'b0, 1'b1, '{mtsed_pkg::CHAR_GT, 1'b1, 1'b0}},
      '{mtsed_pkg::CHAR_AMP,   1'b0, 1'b0, NO_CHAR},
      '{"#",                   1'b0, 1'b0, NO_CHAR},
      '{mtsed_pkg::CHAR_MINUS, 1'b0, 1'b0, NO_CHAR},
      '{"1",                   1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
      '{mtsed_pkg::CHAR_AMP,   1'b0, 1'b0, NO_CHAR},
      '{"q",                   1'b0, 1'b0, NO_CHAR},
      '{"z",                   1'b0, 1'b0, NO_CHAR},
      '{"z",                   1'b0, 1'b0, NO_CHAR},
      '{"z",                   1'b0, 1'b0, NO_CHAR},
      '{"z",                   1'b0, 1'b0, NO_CHAR},
      '{"z",                   1'b0, 1'b1, '{mtsed_pkg::CHAR_QUERY, 1'b1, 1'b0}},
      '{mtsed_pkg::CHAR_SEMI,  1'b0, 1'b0, NO_CHAR},
      '{mtsed_pkg::CHAR_LF,    1'b0, 1'b1, END_ONLY},
      '{"C",                   1'b1, 1'b0, NO_CHAR},
      '{mtsed_pkg::CHAR_AMP,   1'b0, 1'b0, NO_CHAR},
      '{mtsed_pkg::CHAR_NUL,   1'b0, 1'b1, '{mtsed_pkg::CHAR_QUERY, 1'b1, 1'b1}},
      '{"D",                   1'b1, 1'b0, NO_CHAR}
   };

   localparam logic [15:0] CAP_STEPS [12] = '{16'd1, 16'd3, 16'd0, 16'd65535, 16'd7, 16'd2,
                                              16'd12, 16'd512, 16'd5, 16'd40, 16'd1, 16'd9};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [7:0] out_char
   logic        rsp_tuser;           // [0] char_valid
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   // Filter state as the block should hold it.
   logic [15:0]         cap_chars;
   logic signed [15:0]  depth;
   logic [7:0]          ent_bytes [ENT_SPAN-1];
   int                  ent_len;
   mtsed_pkg::mode_type text_mode;
   logic [15:0]         char_count;

   text_char_type expected_chars [$];
   logic [7:0]    text_buf [$];
   string         entity_names [5] = '{"amp", "lt", "gt", "nbsp", "apos"};
   string         hex_pool = "0123456789abcdefABCDEFg";

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          stall_request = 1'b0;
   int          stall_count = 0;
   int          sent_items = 0;
   int          mismatches = 0;
   int unsigned cycle_count = 0;

   markup_tag_strip_entity_decode_unit #(.ENTITY_SPAN(ENT_SPAN)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void restart_text();
      depth = 16'sd0;
      ent_len = 0;
      text_mode = mtsed_pkg::MODE_NORMAL;
      char_count = 16'd0;
   endfunction

   function automatic logic [3:0] hex_weight(input logic [7:0] c, output logic ok);
      ok = 1'b1;
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      ok = 1'b0;
      return 4'd0;
   endfunction

   // Numeric entity value, scanned like the C %i conversion.
   function automatic logic [7:0] number_value();
      int unsigned pos;
      int unsigned base;
      logic [31:0] acc;
      logic [3:0]  w;
      logic        ok;
      logic        neg;
      pos = 1;
      base = 10;
      acc = 32'd0;
      neg = 1'b0;
      while (pos < ent_len && (ent_bytes[pos] == mtsed_pkg::CHAR_SPACE ||
             (ent_bytes[pos] >= 8'd9 && ent_bytes[pos] <= 8'd13)))
         pos++;
      if (pos < ent_len && (ent_bytes[pos] == mtsed_pkg::CHAR_PLUS ||
                            ent_bytes[pos] == mtsed_pkg::CHAR_MINUS)) begin
         neg = (ent_bytes[pos] == mtsed_pkg::CHAR_MINUS);
         pos++;
      end
      if (pos < ent_len && ent_bytes[pos] == mtsed_pkg::CHAR_ZERO) begin
         if (pos + 1 < ent_len && (ent_bytes[pos+1] == "x" || ent_bytes[pos+1] == "X")) begin
            base = 16;
            pos += 2;
         end else begin
            base = 8;
         end
      end
      while (pos < ent_len) begin
         w = hex_weight(ent_bytes[pos], ok);
         if (!ok || w >= base) break;
         acc = acc * base + w;
         pos++;
      end
      if (neg) acc = 32'd0 - acc;
      return acc[7:0];
   endfunction

   function automatic logic name_match(input string name);
      if (ent_len < name.len()) return 1'b0;
      for (int i = 0; i < name.len(); i++)
         if (ent_bytes[i] != name[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] entity_char();
      if (name_match("amp")) return mtsed_pkg::CHAR_AMP;
      if (name_match("lt")) return mtsed_pkg::CHAR_LT;
      if (name_match("gt")) return mtsed_pkg::CHAR_GT;
      if (name_match("nbsp")) return mtsed_pkg::CHAR_SPACE;
      if (name_match("apos")) return mtsed_pkg::CHAR_APOS;
      if (name_match("#")) return number_value();
      return mtsed_pkg::CHAR_QUERY;
   endfunction

   function automatic text_char_type count_char(input logic [7:0] c, input logic end_now);
      text_char_type r;
      logic          cut;
      if (char_count != 16'hFFFF) char_count++;
      cut = (cap_chars != 16'd0) && (char_count >= cap_chars);
      if (end_now || cut) text_mode = mtsed_pkg::MODE_DONE;
      r.ch = c;
      r.valid = 1'b1;
      r.last = end_now || cut;
      return r;
   endfunction

   // Advances the filter state by one byte; returns 1 when the byte yields a result.
   function automatic bit filter_byte(input logic [7:0] b, input logic l,
                                      output text_char_type r);
      logic [7:0] c;
      logic       ends;
      logic       drop;
      r = END_ONLY;
      case (text_mode)
         mtsed_pkg::MODE_DONE: begin
            if (l) restart_text();
            return 1'b0;
         end
         mtsed_pkg::MODE_SWALLOW: begin
            if (b == mtsed_pkg::CHAR_NUL || l) begin
               if (l) restart_text();
               else text_mode = mtsed_pkg::MODE_DONE;
               return 1'b1;
            end
            text_mode = mtsed_pkg::MODE_NORMAL;
            return 1'b0;
         end
         mtsed_pkg::MODE_WINDOW: begin
            ends = l || (b == mtsed_pkg::CHAR_NUL);
            if (b == mtsed_pkg::CHAR_NUL || b == mtsed_pkg::CHAR_SEMI) begin
               c = entity_char();
               text_mode = mtsed_pkg::MODE_NORMAL;
            end else begin
               if (ent_len < ENT_SPAN - 1) begin
                  ent_bytes[ent_len] = b;
                  ent_len++;
               end
               if (ent_len >= ENT_SPAN - 1) begin
                  c = entity_char();
                  text_mode = mtsed_pkg::MODE_SWALLOW;
               end else if (l) begin
                  c = entity_char();
               end else begin
                  return 1'b0;
               end
            end
            r = count_char(c, ends);
            if (l) restart_text();
            return 1'b1;
         end
         default: begin
            if (b == mtsed_pkg::CHAR_NUL || b == mtsed_pkg::CHAR_LF) begin
               if (l) restart_text();
               else text_mode = mtsed_pkg::MODE_DONE;
               return 1'b1;
            end
            if (b == mtsed_pkg::CHAR_CR) begin
               drop = 1'b1;
            end else if (b == mtsed_pkg::CHAR_LT) begin
               if (depth != mtsed_pkg::DEPTH_MAX) depth++;
               drop = (depth > 0);
            end else if (b == mtsed_pkg::CHAR_GT) begin
               if (depth != mtsed_pkg::DEPTH_MIN) depth--;
               drop = 1'b1;
            end else begin
               drop = (depth > 0);
            end
            if (drop) begin
               if (l) restart_text();
               return l;
            end
            if (b == mtsed_pkg::CHAR_AMP) begin
               ent_len = 0;
               if (l) begin
                  r = count_char(entity_char(), 1'b1);
                  restart_text();
                  return 1'b1;
               end
               text_mode = mtsed_pkg::MODE_WINDOW;
               return 1'b0;
            end
            r = count_char(b, l);
            if (l) restart_text();
            return 1'b1;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t ns: result with none expected: char=%h valid=%b last=%b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatches++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== want.ch || rsp_tuser !== want.valid || rsp_tlast !== want.last) begin
               $display("%0t ns: expected char=%h valid=%b last=%b, got char=%h valid=%b last=%b",
                        $time, want.ch, want.valid, want.last, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // Result side: random back-pressure, plus one long hold-off when requested.
   always @(negedge clock) begin
      if (stall_request) begin
         rsp_tready <= 1'b0;
         stall_count++;
         if (stall_count == STALL_CYCLES) begin
            stall_request = 1'b0;
            stall_count = 0;
         end
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_byte(input logic [7:0] b, input logic l);
      text_char_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
      if (filter_byte(b, l, got)) expected_chars.push_back(got);
      @(negedge clock);
   endtask

   // Register writes happen only with the filter drained and quiet.
   task automatic write_cap(input logic [15:0] v);
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cap_chars = v;
   endtask

   task automatic add_str(input string s, input int n);
      for (int i = 0; i < n && i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   // One source text built from tags, entities, plain runs and noise.
   task automatic send_text();
      int         segs;
      int         n;
      int         pre;
      string      name;
      logic [7:0] closing;
      text_buf.delete();
      segs = $urandom_range(1, 6);
      for (int j = 0; j < segs; j++) begin
         case ($urandom_range(0, 15)) inside
            [0:3]: begin
               repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(32, 126)));
            end
            [4:5]: begin
               text_buf.push_back(mtsed_pkg::CHAR_LT);
               repeat ($urandom_range(0, 4)) text_buf.push_back(8'($urandom_range(97, 122)));
               if ($urandom_range(0, 3) != 0) text_buf.push_back(mtsed_pkg::CHAR_GT);
            end
            6: text_buf.push_back(mtsed_pkg::CHAR_GT);
            [7:8]: begin
               name = entity_names[$urandom_range(0, 4)];
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, name.len()) : name.len();
               text_buf.push_back(mtsed_pkg::CHAR_AMP);
               add_str(name, n);
               if ($urandom_range(0, 4) == 0) text_buf.push_back(8'($urandom_range(97, 122)));
               if ($urandom_range(0, 5) != 0) text_buf.push_back(mtsed_pkg::CHAR_SEMI);
            end
            [9:10]: begin
               text_buf.push_back(mtsed_pkg::CHAR_AMP);
               text_buf.push_back("#");
               if ($urandom_range(0, 3) == 0)
                  text_buf.push_back($urandom_range(0, 1) ? mtsed_pkg::CHAR_SPACE : 8'd9);
               if ($urandom_range(0, 2) == 0)
                  text_buf.push_back($urandom_range(0, 1) ? mtsed_pkg::CHAR_MINUS
                                                          : mtsed_pkg::CHAR_PLUS);
               pre = $urandom_range(0, 2);
               if (pre != 0) text_buf.push_back(mtsed_pkg::CHAR_ZERO);
               if (pre == 2) text_buf.push_back($urandom_range(0, 1) ? "x" : "X");
               repeat ($urandom_range(0, 4)) begin
                  if (pre == 2) text_buf.push_back(hex_pool[$urandom_range(0, hex_pool.len() - 1)]);
                  else text_buf.push_back(hex_pool[$urandom_range(0, 10)]);
               end
               if ($urandom_range(0, 5) != 0) text_buf.push_back(mtsed_pkg::CHAR_SEMI);
            end
            11: begin
               text_buf.push_back(mtsed_pkg::CHAR_AMP);
               repeat ($urandom_range(0, 8)) text_buf.push_back(8'($urandom_range(1, 255)));
            end
            12: text_buf.push_back(mtsed_pkg::CHAR_CR);
            13: text_buf.push_back(8'($urandom_range(0, 255)));
            14: begin
               if ($urandom_range(0, 3) == 0)
                  text_buf.push_back($urandom_range(0, 1) ? mtsed_pkg::CHAR_LF
                                                          : mtsed_pkg::CHAR_NUL);
               else
                  text_buf.push_back(mtsed_pkg::CHAR_CR);
            end
            default: begin
               repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(128, 255)));
            end
         endcase
      end
      case ($urandom_range(0, 7)) inside
         [0:3]: closing = 8'($urandom_range(32, 126));
         4: closing = mtsed_pkg::CHAR_AMP;
         5: closing = mtsed_pkg::CHAR_SEMI;
         6: closing = mtsed_pkg::CHAR_GT;
         default: closing = 8'($urandom_range(0, 255));
      endcase
      for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], 1'b0);
      send_byte(closing, 1'b1);
   endtask

   initial begin
      int  cap_step;
      int  next_cap_at;
      int  phase_end;
      bit  stall_used;
      cap_chars = 16'd512;
      restart_text();
      cap_step = 0;
      stall_used = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows run with both sides always ready.
      for (int i = 0; i < 27; i++) begin
         send_byte(DIR_ROWS[i].b, DIR_ROWS[i].l);
         if (DIR_ROWS[i].typed)
            expected_chars[expected_chars.size() - 1] = DIR_ROWS[i].want;
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 83 : 0;
         recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 21 : 0;
         next_cap_at = sent_items;
         phase_end = sent_items + PHASE_ITEMS;
         while (sent_items < phase_end) begin
            if (sent_items >= next_cap_at) begin
               write_cap(CAP_STEPS[cap_step % 12]);
               cap_step++;
               next_cap_at = sent_items + ITEMS_PER_CAP;
            end
            if (phase == 2 && !stall_used && sent_items >= phase_end - 300) begin
               stall_request = 1'b1;
               stall_used = 1'b1;
            end
            send_text();
         end
      end

      // With no cap, every copied byte shows up, including a '<' at negative depth.
      write_cap(16'd0);
      repeat (3) send_byte(mtsed_pkg::CHAR_GT, 1'b0);
      send_byte("a", 1'b0);
      repeat (2) send_byte(mtsed_pkg::CHAR_LT, 1'b0);
      send_byte("b", 1'b1);

      // A cap lowered below the count so far cuts the next character.
      repeat (8) send_byte("x", 1'b0);
      write_cap(16'd3);
      send_byte("y", 1'b0);
      send_byte("z", 1'b1);

      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
